// File: src/fad_pkg.sv
// fad_pkg: shared widths, register indexes, reset values and the cordic
// arctangent table for the fm/am discriminator
// no dependencies
package fad_pkg;

    localparam int CORDIC_STAGES_DEF = 16;

    localparam int SAMPLE_W   = 16;
    localparam int DISC_W     = 20;
    localparam int GAIN_W     = 16;
    localparam int POLE_W     = 24;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // datapath widths
    localparam int VEC_W      = 36;  // cordic x/y, holds the grown product vector
    localparam int ANG_W      = 28;  // angle, 2^24 per pi
    localparam int MAG_W      = 24;  // envelope magnitude, 2^-23 units
    localparam int RAD_W      = 2 * MAG_W;
    localparam int MUL_A_W    = 28;
    localparam int MUL_B_W    = 26;
    localparam int ACC_W      = MUL_A_W + MUL_B_W;
    localparam int ATAN_IDX_W = 5;
    localparam int ATAN_W     = 23;

    localparam int FM_SHIFT = 18;
    localparam int AM_SHIFT = 17;

    localparam logic signed [ANG_W-1:0] ANG_PI = ANG_W'(1) << 24;
    localparam logic [MUL_B_W-1:0] POLE_ONE = MUL_B_W'(1) << POLE_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEMOD_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FM_GAIN    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_AM_GAIN    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DC_POLE    = CFG_IDX_W'(3);

    localparam logic MODE_FM = 1'b0;
    localparam logic MODE_AM = 1'b1;

    localparam logic [GAIN_W-1:0] FM_GAIN_RST = 16'd6433;
    localparam logic [GAIN_W-1:0] AM_GAIN_RST = 16'd2048;
    localparam logic [POLE_W-1:0] DC_POLE_RST = 24'd16775818;

    typedef struct packed {
        logic en;
        logic clr;
        logic sub;
    } t_mac_cmd;

    // atan(2^-k)/pi in units of 2^-24
    function automatic logic [ATAN_W-1:0] atan_step(input logic [ATAN_IDX_W-1:0] k);
        logic [ATAN_W-1:0] v;
        case (k)
            5'd0:    v = 23'd4194304;
            5'd1:    v = 23'd2476042;
            5'd2:    v = 23'd1308273;
            5'd3:    v = 23'd664100;
            5'd4:    v = 23'd333339;
            5'd5:    v = 23'd166832;
            5'd6:    v = 23'd83436;
            5'd7:    v = 23'd41721;
            5'd8:    v = 23'd20861;
            5'd9:    v = 23'd10430;
            5'd10:   v = 23'd5215;
            5'd11:   v = 23'd2608;
            5'd12:   v = 23'd1304;
            5'd13:   v = 23'd652;
            5'd14:   v = 23'd326;
            5'd15:   v = 23'd163;
            5'd16:   v = 23'd81;
            5'd17:   v = 23'd41;
            5'd18:   v = 23'd20;
            5'd19:   v = 23'd10;
            5'd20:   v = 23'd5;
            5'd21:   v = 23'd3;
            5'd22:   v = 23'd1;
            5'd23:   v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

// File: src/fad_ifs.sv
// fad_ifs: valid/ready channel interfaces for samples, results and register writes
// depends on fad_pkg
interface fad_sample_if import fad_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_i;
    logic signed [SAMPLE_W-1:0] sample_q;

    modport source (output valid, output sample_i, output sample_q, input ready);
    modport sink (input valid, input sample_i, input sample_q, output ready);
endinterface

interface fad_result_if import fad_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DISC_W-1:0] disc_value;

    modport source (output valid, output disc_value, input ready);
    modport sink (input valid, input disc_value, output ready);
endinterface

interface fad_cfg_if import fad_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/fad_mac.sv
// fad_mac: shared multiply-accumulate unit, registered product then accumulate
// depends on fad_pkg
module fad_mac import fad_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_mac_cmd                  i_cmd,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [ACC_W-1:0]   o_acc
);

    t_mac_cmd                r_cmd;
    logic signed [ACC_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [ACC_W-1:0] w_base;

    always_comb begin
        w_base = r_cmd.clr ? '0 : r_acc;
        n_acc  = r_cmd.sub ? (w_base - r_prod) : (w_base + r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= '0;
        end else begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (r_cmd.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

// File: src/fad_cordic.sv
// fad_cordic: iterative vectoring cordic, one micro-rotation per cycle,
// returns the phase of (re, im) with 2^24 per pi; depends on fad_pkg
module fad_cordic import fad_pkg::*; #(
    parameter int STAGES = CORDIC_STAGES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [VEC_W-1:0] i_re,
    input  logic signed [VEC_W-1:0] i_im,
    output logic                    o_done,
    output logic signed [ANG_W-1:0] o_angle
);

    localparam int KW = $clog2(STAGES);

    logic                    r_busy;
    logic                    r_done;
    logic [KW-1:0]           r_k;
    logic signed [VEC_W-1:0] r_x;
    logic signed [VEC_W-1:0] r_y;
    logic signed [ANG_W-1:0] r_z;
    logic signed [VEC_W-1:0] w_sx;
    logic signed [VEC_W-1:0] w_sy;
    logic signed [ANG_W-1:0] w_step;

    assign w_sx   = r_x >>> r_k;
    assign w_sy   = r_y >>> r_k;
    assign w_step = signed'(ANG_W'(atan_step(ATAN_IDX_W'(r_k))));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                if (r_k == KW'(STAGES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // left half plane: turn by pi first
            if (i_re < 0) begin
                r_x <= -i_re;
                r_y <= -i_im;
                r_z <= (i_im >= 0) ? ANG_PI : -ANG_PI;
            end else begin
                r_x <= i_re;
                r_y <= i_im;
                r_z <= '0;
            end
        end else if (r_busy && r_y != 0) begin
            if (r_y > 0) begin
                r_x <= r_x + w_sy;
                r_y <= r_y - w_sx;
                r_z <= r_z + w_step;
            end else begin
                r_x <= r_x - w_sy;
                r_y <= r_y + w_sx;
                r_z <= r_z - w_step;
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_z;

endmodule

// File: src/fad_isqrt.sv
// fad_isqrt: restoring integer square root, one result bit per cycle
// depends on fad_pkg
module fad_isqrt import fad_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [RAD_W-1:0] i_rad,
    output logic             o_done,
    output logic [MAG_W-1:0] o_root
);

    localparam int CW = $clog2(MAG_W);

    logic               r_busy;
    logic               r_done;
    logic [CW-1:0]      r_cnt;
    logic [RAD_W-1:0]   r_rad;
    logic [MAG_W+1:0]   r_rem;
    logic [MAG_W-1:0]   r_root;
    logic [MAG_W+1:0]   w_cur;
    logic [MAG_W+1:0]   w_trial;

    // remainder stays below 2^24 before every step, so the shift loses nothing
    assign w_cur   = {r_rem[MAG_W-1:0], r_rad[RAD_W-1 -: 2]};
    assign w_trial = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[RAD_W-3:0], 2'b00};
            if (w_cur >= w_trial) begin
                r_rem  <= w_cur - w_trial;
                r_root <= {r_root[MAG_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_cur;
                r_root <= {r_root[MAG_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// File: src/fm_am_discriminator.sv
// fm_am_discriminator: one complex sample in, one discriminator sample out.
// FM mode takes the phase of the sample times the conjugate of the previous
// one and scales it by fm_gain; AM mode takes the envelope, removes its
// one-pole average and scales by am_gain; the result is saturated Q4.15.
// The block works on one sample at a time and is not ready while it does.
// The time of an FM sample is set by the iterative cordic that does one
// micro-rotation per cycle; that of an AM sample is set by the square root
// that makes one magnitude bit per cycle.
// All products go through a single shared multiply-accumulate unit. A result
// waits in an output register, so the next sample is taken while it is held.
// Depends on fad_pkg, fad_ifs, fad_mac, fad_cordic and fad_isqrt.
module fm_am_discriminator import fad_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    fad_sample_if.sink          i_sample,
    fad_result_if.source        o_result,
    fad_cfg_if.sink             i_cfg
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_FRE0, S_FRE1, S_FIM0, S_FIM1, S_FW0, S_FW1, S_FROT,
        S_AP0, S_AP1, S_AW0, S_AW1, S_ASQ, S_AE1, S_AEW0, S_AEW1, S_AD,
        S_GW, S_PUSH
    } t_state;

    localparam logic signed [ACC_W-1:0] SAT_HI  = (ACC_W'(1) << (DISC_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_LO  = -(ACC_W'(1) << (DISC_W - 1));
    localparam logic signed [ACC_W-1:0] RND_FM  = ACC_W'(1) << (FM_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] RND_AM  = ACC_W'(1) << (AM_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] RND_AVG = ACC_W'(1) << (POLE_W - 1);

    t_state                     r_state;
    logic                       r_mode;
    logic [GAIN_W-1:0]          r_fm_gain;
    logic [GAIN_W-1:0]          r_am_gain;
    logic [POLE_W-1:0]          r_dc_pole;
    logic signed [SAMPLE_W-1:0] r_last_i;
    logic signed [SAMPLE_W-1:0] r_last_q;
    logic [MAG_W-1:0]           r_avg;
    logic signed [SAMPLE_W-1:0] r_si;
    logic signed [SAMPLE_W-1:0] r_sq;
    logic signed [VEC_W-1:0]    r_re;
    logic [MAG_W-1:0]           r_mag;
    logic                       r_out_valid;
    logic signed [DISC_W-1:0]   r_out;

    t_mac_cmd                   w_mac_cmd;
    logic signed [MUL_A_W-1:0]  w_mac_a;
    logic signed [MUL_B_W-1:0]  w_mac_b;
    logic signed [ACC_W-1:0]    w_acc;
    logic                       w_cordic_done;
    logic signed [ANG_W-1:0]    w_angle;
    logic                       w_sqrt_done;
    logic [MAG_W-1:0]           w_root;
    logic signed [MAG_W+1:0]    w_diff;
    logic signed [ACC_W-1:0]    w_avg_sum;
    logic signed [ACC_W-1:0]    w_scaled;
    logic signed [ACC_W-1:0]    w_sat;
    logic                       w_in_xfer;
    logic                       w_out_free;

    assign w_in_xfer  = i_sample.valid && i_sample.ready;
    assign w_out_free = !r_out_valid || o_result.ready;

    assign i_sample.ready    = (r_state == S_IDLE);
    assign o_result.valid    = r_out_valid;
    assign o_result.disc_value = r_out;
    assign i_cfg.ready       = 1'b1;

    assign w_diff    = signed'({2'b00, r_mag}) - signed'({2'b00, r_avg});
    assign w_avg_sum = w_acc + RND_AVG;

    always_comb begin
        if (r_mode == MODE_FM) begin
            w_scaled = (w_acc + RND_FM) >>> FM_SHIFT;
        end else begin
            w_scaled = (w_acc + RND_AM) >>> AM_SHIFT;
        end
        if (w_scaled > SAT_HI) begin
            w_sat = SAT_HI;
        end else if (w_scaled < SAT_LO) begin
            w_sat = SAT_LO;
        end else begin
            w_sat = w_scaled;
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        w_mac_cmd = '0;
        w_mac_a   = '0;
        w_mac_b   = '0;
        case (r_state)
            S_FRE0: begin
                w_mac_cmd = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
                w_mac_a   = {{(MUL_A_W-SAMPLE_W){r_si[SAMPLE_W-1]}}, r_si};
                w_mac_b   = {{(MUL_B_W-SAMPLE_W){r_last_i[SAMPLE_W-1]}}, r_last_i};
            end
            S_FRE1: begin
                w_mac_cmd = '{en: 1'b1, clr: 1'b0, sub: 1'b0};
                w_mac_a   = {{(MUL_A_W-SAMPLE_W){r_sq[SAMPLE_W-1]}}, r_sq};
                w_mac_b   = {{(MUL_B_W-SAMPLE_W){r_last_q[SAMPLE_W-1]}}, r_last_q};
            end
            S_FIM0: begin
                w_mac_cmd = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
                w_mac_a   = {{(MUL_A_W-SAMPLE_W){r_sq[SAMPLE_W-1]}}, r_sq};
                w_mac_b   = {{(MUL_B_W-SAMPLE_W){r_last_i[SAMPLE_W-1]}}, r_last_i};
            end
            S_FIM1: begin
                w_mac_cmd = '{en: 1'b1, clr: 1'b0, sub: 1'b1};
                w_mac_a   = {{(MUL_A_W-SAMPLE_W){r_si[SAMPLE_W-1]}}, r_si};
                w_mac_b   = {{(MUL_B_W-SAMPLE_W){r_last_q[SAMPLE_W-1]}}, r_last_q};
            end
            S_FROT: begin
                w_mac_cmd = '{en: w_cordic_done, clr: 1'b1, sub: 1'b0};
                w_mac_a   = w_angle;
                w_mac_b   = {{(MUL_B_W-GAIN_W){1'b0}}, r_fm_gain};
            end
            S_AP0: begin
                w_mac_cmd = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
                w_mac_a   = {{(MUL_A_W-SAMPLE_W){r_si[SAMPLE_W-1]}}, r_si};
                w_mac_b   = {{(MUL_B_W-SAMPLE_W){r_si[SAMPLE_W-1]}}, r_si};
            end
            S_AP1: begin
                w_mac_cmd = '{en: 1'b1, clr: 1'b0, sub: 1'b0};
                w_mac_a   = {{(MUL_A_W-SAMPLE_W){r_sq[SAMPLE_W-1]}}, r_sq};
                w_mac_b   = {{(MUL_B_W-SAMPLE_W){r_sq[SAMPLE_W-1]}}, r_sq};
            end
            S_ASQ: begin
                w_mac_cmd = '{en: w_sqrt_done, clr: 1'b1, sub: 1'b0};
                w_mac_a   = {{(MUL_A_W-MAG_W){1'b0}}, r_avg};
                w_mac_b   = {{(MUL_B_W-POLE_W){1'b0}}, r_dc_pole};
            end
            S_AE1: begin
                w_mac_cmd = '{en: 1'b1, clr: 1'b0, sub: 1'b0};
                w_mac_a   = {{(MUL_A_W-MAG_W){1'b0}}, r_mag};
                w_mac_b   = signed'(POLE_ONE - {{(MUL_B_W-POLE_W){1'b0}}, r_dc_pole});
            end
            S_AD: begin
                w_mac_cmd = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
                w_mac_a   = {{(MUL_A_W-MAG_W-2){w_diff[MAG_W+1]}}, w_diff};
                w_mac_b   = {{(MUL_B_W-GAIN_W){1'b0}}, r_am_gain};
            end
            default: begin
                w_mac_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_FM;
            r_fm_gain   <= FM_GAIN_RST;
            r_am_gain   <= AM_GAIN_RST;
            r_dc_pole   <= DC_POLE_RST;
            r_last_i    <= '0;
            r_last_q    <= '0;
            r_avg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_DEMOD_MODE: r_mode    <= i_cfg.data[0];
                    REG_FM_GAIN:    r_fm_gain <= i_cfg.data[GAIN_W-1:0];
                    REG_AM_GAIN:    r_am_gain <= i_cfg.data[GAIN_W-1:0];
                    REG_DC_POLE:    r_dc_pole <= i_cfg.data[POLE_W-1:0];
                    default: ;
                endcase
            end

            // a new result may replace one that leaves at the same edge
            if (r_state == S_PUSH && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_state <= (r_mode == MODE_FM) ? S_FRE0 : S_AP0;
                    end
                end
                S_FRE0: r_state <= S_FRE1;
                S_FRE1: r_state <= S_FIM0;
                S_FIM0: r_state <= S_FIM1;
                S_FIM1: r_state <= S_FW0;
                S_FW0:  r_state <= S_FW1;
                S_FW1:  r_state <= S_FROT;
                S_FROT: begin
                    if (w_cordic_done) begin
                        r_state <= S_GW;
                    end
                end
                S_AP0:  r_state <= S_AP1;
                S_AP1:  r_state <= S_AW0;
                S_AW0:  r_state <= S_AW1;
                S_AW1:  r_state <= S_ASQ;
                S_ASQ: begin
                    if (w_sqrt_done) begin
                        r_state <= S_AE1;
                    end
                end
                S_AE1:  r_state <= S_AEW0;
                S_AEW0: r_state <= S_AEW1;
                S_AEW1: begin
                    r_avg   <= w_avg_sum[POLE_W +: MAG_W];
                    r_state <= S_AD;
                end
                S_AD:   r_state <= S_GW;
                S_GW:   r_state <= S_PUSH;
                S_PUSH: begin
                    if (w_out_free) begin
                        r_last_i    <= r_si;
                        r_last_q    <= r_sq;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_si <= i_sample.sample_i;
            r_sq <= i_sample.sample_q;
        end
        // real part is complete in the accumulator while the imaginary one starts
        if (r_state == S_FIM1) begin
            r_re <= w_acc[VEC_W-1:0];
        end
        if (r_state == S_ASQ && w_sqrt_done) begin
            r_mag <= w_root;
        end
        if (r_state == S_PUSH && w_out_free) begin
            r_out <= w_sat[DISC_W-1:0];
        end
    end

    fad_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_mac_cmd),
        .i_a     (w_mac_a),
        .i_b     (w_mac_b),
        .o_acc   (w_acc)
    );

    fad_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_FW1),
        .i_re    (r_re),
        .i_im    (w_acc[VEC_W-1:0]),
        .o_done  (w_cordic_done),
        .o_angle (w_angle)
    );

    fad_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_AW1),
        .i_rad   ({w_acc[31:0], {(RAD_W-32){1'b0}}}),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !i_sample.ready)
        else $error("input accepted while a sample is in work");

    a_avg_held_in_fm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_FM && r_state != S_IDLE) |=> $stable(r_avg))
        else $error("envelope average changed in fm mode");

    a_mac_quiet_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_mac_cmd.en)
        else $error("multiplier issued while idle");

    a_push_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH && r_out_valid && !o_result.ready) |=> (r_state == S_PUSH))
        else $error("pending result overwritten");

endmodule

// File: bench/fad_disc_checker.sv
// fad_disc_checker: watches the sample, result and register write channels of
// the fm/am discriminator, predicts every discriminator sample and compares it
// depends on fad_pkg
module fad_disc_checker import fad_pkg::*; #(
    parameter int STAGES = CORDIC_STAGES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_smp_valid,
    input  logic                       i_smp_ready,
    input  logic signed [SAMPLE_W-1:0] i_smp_i,
    input  logic signed [SAMPLE_W-1:0] i_smp_q,
    input  logic                       i_res_valid,
    input  logic                       i_res_ready,
    input  logic signed [DISC_W-1:0]   i_res_disc,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_checked
);

    localparam int     ATAN_LEN   = 24;
    localparam int     REPORT_CAP = 100;
    localparam longint HALF_TURN  = 64'sd1 <<< 24;
    localparam longint DISC_MAX   = (64'sd1 <<< (DISC_W - 1)) - 1;
    localparam longint DISC_MIN   = -(64'sd1 <<< (DISC_W - 1));

    // atan(2^-k)/pi, 2^24 per half turn
    longint atan_units [0:ATAN_LEN-1] = '{
        4194304, 2476042, 1308273, 664100, 333339, 166832, 83436, 41721,
        20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1, 1
    };

    logic   mode_sel;
    longint fm_gain_q;
    longint am_gain_q;
    longint pole_q;
    longint prev_i;
    longint prev_q;
    longint env_avg;

    logic signed [DISC_W-1:0] disc_q [$];
    int err_cnt = 0;
    int chk_cnt = 0;

    function automatic longint clamp_disc(input longint v);
        if (v > DISC_MAX) return DISC_MAX;
        if (v < DISC_MIN) return DISC_MIN;
        return v;
    endfunction

    function automatic longint root_floor(input longint v);
        longint rem;
        longint root;
        longint b;
        rem  = v;
        root = 0;
        b    = 64'sd1 <<< 62;
        while (b > rem) b = b >>> 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem  = rem - (root + b);
                root = (root >>> 1) + b;
            end else begin
                root = root >>> 1;
            end
            b = b >>> 2;
        end
        return root;
    endfunction

    // vectoring rotation, angle in 2^24 per half turn
    function automatic longint phase_units(input longint re, input longint im);
        longint vx;
        longint vy;
        longint z;
        longint nx;
        longint ny;
        longint step;
        vx = re;
        vy = im;
        z  = 0;
        if (re == 0 && im == 0) return 0;
        // left half plane: flip by a half turn first
        if (vx < 0) begin
            vx = -vx;
            vy = -vy;
            z  = (im >= 0) ? HALF_TURN : -HALF_TURN;
        end
        for (int k = 0; k < STAGES; k++) begin
            if (vy != 0) begin
                step = (k < ATAN_LEN) ? atan_units[k] : 0;
                if (vy > 0) begin
                    nx = vx + (vy >>> k);
                    ny = vy - (vx >>> k);
                    z  = z + step;
                end else begin
                    nx = vx - (vy >>> k);
                    ny = vy + (vx >>> k);
                    z  = z - step;
                end
                vx = nx;
                vy = ny;
            end
        end
        return z;
    endfunction

    function automatic logic signed [DISC_W-1:0] demod(input longint si, input longint sq);
        longint re;
        longint im;
        longint mag;
        longint acc;
        longint val;
        if (mode_sel == MODE_FM) begin
            re  = si * prev_i + sq * prev_q;
            im  = sq * prev_i - si * prev_q;
            val = (phase_units(re, im) * fm_gain_q + (64'sd1 <<< (FM_SHIFT - 1))) >>> FM_SHIFT;
        end else begin
            mag     = root_floor((si * si + sq * sq) <<< 16);
            acc     = pole_q * env_avg + ((64'sd1 <<< POLE_W) - pole_q) * mag
                      + (64'sd1 <<< (POLE_W - 1));
            env_avg = acc >>> POLE_W;
            val     = ((mag - env_avg) * am_gain_q + (64'sd1 <<< (AM_SHIFT - 1))) >>> AM_SHIFT;
        end
        prev_i = si;
        prev_q = sq;
        return DISC_W'(clamp_disc(val));
    endfunction

    task automatic flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= REPORT_CAP) $display("%0t: %s", $time, msg);
        if (err_cnt == REPORT_CAP) $display("%0t: further mismatches only counted", $time);
    endtask

    always @(posedge i_clk) begin : watch
        logic signed [DISC_W-1:0] want;
        if (!i_rst_n) begin
            mode_sel  = MODE_FM;
            fm_gain_q = FM_GAIN_RST;
            am_gain_q = AM_GAIN_RST;
            pole_q    = DC_POLE_RST;
            prev_i    = 0;
            prev_q    = 0;
            env_avg   = 0;
            disc_q.delete();
        end else begin
            // results first so a same-edge sample cannot mask an unexpected one
            if (i_res_valid && i_res_ready) begin
                if (disc_q.size() == 0) begin
                    flag_error($sformatf("unexpected result, expected none, actual %0d",
                                         i_res_disc));
                end else begin
                    want = disc_q.pop_front();
                    chk_cnt++;
                    if (want !== i_res_disc)
                        flag_error($sformatf("disc_value mismatch, expected %0d, actual %0d",
                                             want, i_res_disc));
                end
            end
            if (i_smp_valid && i_smp_ready)
                disc_q.push_back(demod(i_smp_i, i_smp_q));
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_DEMOD_MODE: mode_sel = i_cfg_data[0];
                    REG_FM_GAIN:    fm_gain_q = i_cfg_data[GAIN_W-1:0];
                    REG_AM_GAIN:    am_gain_q = i_cfg_data[GAIN_W-1:0];
                    REG_DC_POLE:    pole_q = i_cfg_data[POLE_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending <= disc_q.size();
        o_errors  <= err_cnt;
        o_checked <= chk_cnt;
    end

endmodule

// File: bench/tb_fm_am_discriminator.sv
// tb_fm_am_discriminator: drives samples, register writes and result stalls
// into the fm/am discriminator and gives the verdict from the checker's count
// depends on fad_pkg, fad_ifs, fm_am_discriminator and fad_disc_checker
module tb_fm_am_discriminator;
    import fad_pkg::*;

    localparam int GAP_MAX        = 18;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 136;
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SMP_MAX        = 32767;
    localparam int SMP_MIN        = -32768;

    logic clk;
    logic rst_n = 1'b0;

    fad_sample_if smp_if();
    fad_result_if res_if();
    fad_cfg_if    cfg_if();

    int errors;
    int pending_cnt;
    int checked;

    int   smp_gap_max = 0;
    int   rdy_gap_max = 0;
    logic cur_mode    = MODE_FM;
    int   fm_items    = 0;
    int   am_items    = 0;
    int   settings    = 0;
    int   last_si     = 0;
    int   last_sq     = 0;
    int   stall_cycles = 0;
    real  ph;
    real  freq;
    real  amp;

    fm_am_discriminator u_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_sample (smp_if),
        .o_result (res_if),
        .i_cfg    (cfg_if)
    );

    fad_disc_checker u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_smp_valid (smp_if.valid),
        .i_smp_ready (smp_if.ready),
        .i_smp_i     (smp_if.sample_i),
        .i_smp_q     (smp_if.sample_q),
        .i_res_valid (res_if.valid),
        .i_res_ready (res_if.ready),
        .i_res_disc  (res_if.disc_value),
        .i_cfg_valid (cfg_if.valid),
        .i_cfg_ready (cfg_if.ready),
        .i_cfg_index (cfg_if.index),
        .i_cfg_data  (cfg_if.data),
        .o_errors    (errors),
        .o_pending   (pending_cnt),
        .o_checked   (checked)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // no transfer on any channel for too long means the block hung
    always @(posedge clk) begin
        if (!rst_n || (smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)
            || (cfg_if.valid && cfg_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // result side back-pressure
    initial begin
        int gap;
        res_if.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            gap = $urandom_range(0, rdy_gap_max);
            if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!(res_if.valid && res_if.ready));
        end
    end

    function automatic int gap_pick();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 3;
            default: return GAP_MAX;
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain(input logic [GAIN_W-1:0] dflt);
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return dflt;
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic [POLE_W-1:0] pick_pole();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return DC_POLE_RST;
            3:       return POLE_W'((1 << POLE_W) - $urandom_range(1, 1 << 16));
            default: return POLE_W'($urandom);
        endcase
    endfunction

    function automatic int pick_edge();
        case ($urandom_range(0, 5))
            0:       return SMP_MIN;
            1:       return SMP_MAX;
            2:       return 0;
            3:       return -1;
            4:       return 1;
            default: return $urandom_range(0, 8) - 4;
        endcase
    endfunction

    task automatic send_sample(input int si, input int sq);
        int gap;
        gap = $urandom_range(0, smp_gap_max);
        if (gap > 0) begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        smp_if.valid    <= 1'b1;
        smp_if.sample_i <= SAMPLE_W'(si);
        smp_if.sample_q <= SAMPLE_W'(sq);
        do @(posedge clk); while (!(smp_if.valid && smp_if.ready));
        last_si = si;
        last_sq = sq;
        if (cur_mode == MODE_AM) am_items++;
        else fm_items++;
    endtask

    // hold samples back until every discriminator sample has come out
    task automatic drain();
        smp_if.valid <= 1'b0;
        do @(posedge clk); while (pending_cnt != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    endtask

    task automatic set_config(input logic mode, input logic [GAIN_W-1:0] fmg,
                              input logic [GAIN_W-1:0] amg, input logic [POLE_W-1:0] pole);
        logic [CFG_IDX_W-1:0]  order [4];
        logic [CFG_IDX_W-1:0]  swap;
        logic [CFG_DATA_W-1:0] val;
        int j;
        order = '{REG_DEMOD_MODE, REG_FM_GAIN, REG_AM_GAIN, REG_DC_POLE};
        for (int i = 3; i > 0; i--) begin
            j        = $urandom_range(0, i);
            swap     = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
        foreach (order[i]) begin
            // bits above the register width carry junk
            val = $urandom;
            case (order[i])
                REG_DEMOD_MODE: val[0] = mode;
                REG_FM_GAIN:    val[GAIN_W-1:0] = fmg;
                REG_AM_GAIN:    val[GAIN_W-1:0] = amg;
                default:        val[POLE_W-1:0] = pole;
            endcase
            write_reg(order[i], val);
        end
        if ($urandom_range(0, 1))
            write_reg(CFG_IDX_W'($urandom_range(REG_DC_POLE + 1, (1 << CFG_IDX_W) - 1)),
                      $urandom);
        cfg_if.valid <= 1'b0;
        cur_mode = mode;
        settings++;
    endtask

    task automatic random_sample(output int si, output int sq);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                // rotating phasor with a wandering envelope
                ph  = ph + freq;
                amp = amp + real'($urandom_range(0, 400)) - 200.0;
                if (amp > 32767.0) amp = 32767.0;
                if (amp < 0.0) amp = 0.0;
                si = int'(amp * $cos(ph));
                sq = int'(amp * $sin(ph));
            end
            5, 6: begin
                si = $signed(SAMPLE_W'($urandom));
                sq = $signed(SAMPLE_W'($urandom));
            end
            7: begin
                si = pick_edge();
                sq = pick_edge();
            end
            8: begin
                si = last_si;
                sq = last_sq;
            end
            default: begin
                // roughly opposite to the last sample
                si = -last_si - 1;
                sq = -last_sq - 1;
            end
        endcase
    endtask

    initial begin
        int si;
        int sq;
        smp_if.valid    <= 1'b0;
        smp_if.sample_i <= '0;
        smp_if.sample_q <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= '0;
        cfg_if.data     <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // fm with reset gains: zero vector, zero angle, half turn, quadrants
        smp_gap_max = gap_pick();
        rdy_gap_max = gap_pick();
        send_sample(0, 0);
        send_sample(0, 0);
        send_sample(SMP_MAX, 0);
        send_sample(SMP_MAX, 0);
        send_sample(SMP_MIN, 0);
        send_sample(SMP_MAX, SMP_MIN);
        send_sample(SMP_MIN, SMP_MAX);
        send_sample(0, SMP_MIN);
        send_sample(-1, -1);
        send_sample(1, 0);
        drain();

        // full fm gain saturates both ends
        set_config(MODE_FM, '1, AM_GAIN_RST, DC_POLE_RST);
        send_sample(SMP_MAX, 0);
        send_sample(0, SMP_MAX);
        send_sample(SMP_MAX, 0);
        send_sample(SMP_MIN, 0);
        drain();

        // am with zero pole: average follows the envelope
        set_config(MODE_AM, '0, '1, '0);
        send_sample(SMP_MIN, SMP_MIN);
        send_sample(SMP_MAX, SMP_MAX);
        send_sample(0, 0);
        send_sample(SMP_MIN, SMP_MIN);
        drain();

        // am with the slowest pole: big envelope steps saturate
        set_config(MODE_AM, '0, '1, '1);
        send_sample(0, 0);
        send_sample(SMP_MIN, SMP_MIN);
        send_sample(1, 1);
        send_sample(-1, 0);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            smp_gap_max = gap_pick();
            rdy_gap_max = gap_pick();
            set_config((p % 2 == 0) ? MODE_FM : MODE_AM, pick_gain(FM_GAIN_RST),
                       pick_gain(AM_GAIN_RST), pick_pole());
            ph   = 0.0;
            freq = (real'($urandom_range(0, 2000)) - 1000.0) / 1000.0 * 3.14159;
            amp  = real'($urandom_range(0, SMP_MAX));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_sample(si, sq);
                send_sample(si, sq);
                if ($urandom_range(0, 59) == 0) drain();
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d fm and %0d am samples over %0d register settings",
                 fm_items, am_items, settings + 1);
        $display("%0d results compared, %0d mismatches, %0d still outstanding",
                 checked, errors, pending_cnt);
        if (errors == 0 && pending_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
